### rtl/blr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants for batch loss reduction
// Widths, loss modes and the beat format between front and back.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned SUM_W         = 48;
  localparam int unsigned TERM_W        = 40;
  localparam int unsigned CNT_W         = 25;
  localparam int unsigned LOG_FRAC      = 20;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam int unsigned QDEPTH        = 4;

  typedef enum logic {
    KIND_MSE = 1'b0,
    KIND_BCE = 1'b1
  } loss_kind_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic [15:0]        pc;
    logic               kind;
    logic               clamped;
    logic               last;
  } blr_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_SCALE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } blr_state_t;

endpackage

### rtl/blr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_front: input stage
// Takes pairs, clamps the prediction in cross-entropy mode, queues the beat.
// ----------------------------------------------------------------------------
module blr_front #(
  parameter int unsigned FRAC_BITS = blr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [15:0]         true_value,
  input  logic signed [15:0]         predicted_value,
  input  logic                       last_in_batch,
  input  logic                       kind,
  output logic                       q_valid,
  input  logic                       q_take,
  output blr_pkg::blr_item_t         q_item
);
  import blr_pkg::*;

  localparam logic signed [15:0] ONE_M1 = 16'((1 << FRAC_BITS) - 1);
  localparam int unsigned PW = $clog2(QDEPTH);

  blr_item_t        buf_q [QDEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      fill;
  blr_item_t        item_in;
  logic             do_push, do_pop;

  always_comb begin
    item_in.t       = true_value;
    item_in.pc      = predicted_value;
    item_in.kind    = kind;
    item_in.clamped = 1'b0;
    item_in.last    = last_in_batch;
    if (kind == KIND_BCE) begin
      if (predicted_value < 16'sd1) begin
        item_in.pc      = 16'd1;
        item_in.clamped = 1'b1;
      end else if (predicted_value > ONE_M1) begin
        item_in.pc      = ONE_M1;
        item_in.clamped = 1'b1;
      end
    end
  end

  assign full    = (fill == (PW+1)'(QDEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = buf_q[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_q[wptr] <= item_in;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= (PW+1)'(QDEPTH))
    else $error("front queue overfilled");
  assert property (@(posedge clk) disable iff (rst) full |-> !do_push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> fill == $past(fill) + 1'b1)
    else $error("fill count slip");
endmodule

### rtl/blr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_back: loss and reduction engine
// Per beat: square or two logs by iterated squaring, accumulate; on last
// beat or MAX_ITEMS, restoring division; mean held in an output register.
// ----------------------------------------------------------------------------
module blr_back #(
  parameter int unsigned MAX_ITEMS = blr_pkg::MAX_ITEMS_DEF,
  parameter int unsigned FRAC_BITS = blr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_take,
  input  blr_pkg::blr_item_t         q_item,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [31:0]         mean_loss,
  output logic [16:0]                pair_count,
  output logic                       clamped_seen,
  output logic                       saturated
);
  import blr_pkg::*;

  localparam int unsigned ONE  = 1 << FRAC_BITS;
  localparam int unsigned SH   = 2*FRAC_BITS - 16;
  localparam int unsigned DW   = CNT_W + SH;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  blr_state_t state, state_next;

  blr_item_t               cur;
  logic signed [SUM_W-1:0] loss_sum;
  logic [CNT_W-1:0]        items_seen;
  logic                    clamp_flag, overflow_flag;

  // log unit: one squaring step per cycle, two operands in turn
  logic [31:0]   y;
  logic [4:0]    lstep;
  logic          lsel;
  logic [4:0]    kexp;
  logic [LOG_FRAC-1:0] frac;
  logic [24:0]   nl0, nl1;
  logic [1:0]    scl;
  logic signed [TERM_W-1:0] term;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [5:0]        dstep;
  logic              sneg;

  logic [15:0]  lx;
  logic [4:0]   knorm;
  logic [63:0]  sq;
  logic [31:0]  ysq;
  logic [LOG_FRAC+4:0] nlog2;
  logic [55:0]  lnprod;
  logic [24:0]  nl_new;
  logic signed [SUM_W:0] sum_ext;
  logic [SUM_W:0] rem_sh;
  logic [DW-1:0] dv;
  logic          obusy;

  logic signed [16:0] mse_d;
  logic signed [33:0] mse_sq;
  logic signed [17:0] bce_f;
  logic [17:0]        bce_nl;
  logic signed [36:0] bce_p;

  always_comb begin
    lx    = lsel ? 16'(16'(ONE) - cur.pc) : cur.pc;
    knorm = '0;
    for (int i = 0; i < 16; i++) begin
      if (lx[i]) begin
        knorm = 5'(i);
      end
    end
    sq     = 64'(y) * 64'(y);
    ysq    = 32'(sq >> 30);
    nlog2  = (LOG_FRAC+5)'((LOG_FRAC+5)'(FRAC_BITS - 32'(kexp)) << LOG_FRAC) -
             (LOG_FRAC+5)'(frac);
    lnprod = 56'(nlog2) * 56'(LN2_Q30);
    nl_new = 25'((lnprod + (56'(1) << (49 - FRAC_BITS))) >> (50 - FRAC_BITS));
    sum_ext = 49'(loss_sum) + 49'(term);
    rem_sh  = {rem, quo[SUM_W-1]};
    dv      = DW'(items_seen) << SH;
    mse_d   = 17'(cur.t) - 17'($signed(cur.pc));
    mse_sq  = 34'(mse_d) * 34'(mse_d);
    bce_f   = (scl == 2'd0) ? 18'(cur.t) : 18'(18'(ONE) - 18'(cur.t));
    bce_nl  = (scl == 2'd0) ? nl0[17:0] : nl1[17:0];
    bce_p   = 37'(bce_f) * 37'($signed({1'b0, bce_nl}));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = (q_item.kind == KIND_BCE) ? ST_LOG : ST_SCALE;
      ST_LOG:   if (lsel && lstep == 5'(LOG_FRAC + 1)) state_next = ST_SCALE;
      ST_SCALE: if (scl == 2'd2) state_next = ST_ACC;
      ST_ACC:   if (cur.last || (32'(items_seen) + 1) >= MAX_ITEMS) state_next = ST_DIV;
                else state_next = ST_IDLE;
      ST_DIV:   if (dstep == 6'(SUM_W)) state_next = ST_OUT;
      ST_OUT:   if (!obusy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == ST_IDLE);
  end

  assign empty = !obusy;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur   <= q_item;
        lsel  <= 1'b0;
        lstep <= '0;
        scl   <= '0;
      end
      ST_LOG: begin
        if (lstep == '0) begin
          kexp  <= knorm;
          y     <= 32'(lx) << (30 - knorm);
          frac  <= '0;
          lstep <= 5'd1;
        end else if (lstep <= 5'(LOG_FRAC)) begin
          if (ysq[31]) begin
            y    <= ysq >> 1;
            frac <= frac | (LOG_FRAC'(1) << (LOG_FRAC - 32'(lstep)));
          end else begin
            y <= ysq;
          end
          lstep <= lstep + 1'b1;
        end else begin
          if (lsel) nl1 <= nl_new;
          else nl0 <= nl_new;
          lsel  <= 1'b1;
          lstep <= '0;
        end
      end
      ST_SCALE: begin
        scl <= scl + 1'b1;
        if (cur.kind == KIND_MSE) begin
          term <= TERM_W'(mse_sq);
        end else if (scl == 2'd0) begin
          term <= TERM_W'(bce_p);
        end else if (scl == 2'd1) begin
          term <= term + TERM_W'(bce_p);
        end
      end
      ST_ACC: begin
        rem   <= '0;
        dstep <= '0;
        sneg  <= 1'b0;
      end
      ST_DIV: begin
        if (dstep == '0) begin
          sneg <= loss_sum[SUM_W-1];
          quo  <= loss_sum[SUM_W-1] ? SUM_W'(-loss_sum) : SUM_W'(loss_sum);
          rem  <= '0;
          dstep <= 6'd1;
        end else if (dstep <= 6'(SUM_W)) begin
          if (rem_sh >= (SUM_W+1)'(dv)) rem <= SUM_W'(rem_sh - (SUM_W+1)'(dv));
          else rem <= SUM_W'(rem_sh);
          quo   <= {quo[SUM_W-2:0], rem_sh >= (SUM_W+1)'(dv)};
          dstep <= dstep + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loss_sum      <= '0;
      items_seen    <= '0;
      clamp_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      obusy         <= 1'b0;
    end else begin
      state <= state_next;
      if (obusy && pop) obusy <= 1'b0;
      if (state == ST_ACC) begin
        if (sum_ext > 49'(SUM_MAX)) begin
          loss_sum <= SUM_MAX;
          overflow_flag <= 1'b1;
        end else if (sum_ext < 49'(SUM_MIN)) begin
          loss_sum <= SUM_MIN;
          overflow_flag <= 1'b1;
        end else begin
          loss_sum <= SUM_W'(sum_ext);
        end
        items_seen <= items_seen + 1'b1;
        if (cur.clamped) clamp_flag <= 1'b1;
      end
      if (state == ST_OUT && !obusy) begin
        obusy        <= 1'b1;
        pair_count   <= 17'(items_seen);
        clamped_seen <= clamp_flag;
        if (!sneg && quo > SUM_W'(32'h7FFF_FFFF)) begin
          mean_loss <= 32'sh7FFF_FFFF;
          saturated <= 1'b1;
        end else if (sneg && quo > SUM_W'(33'h8000_0000)) begin
          mean_loss <= 32'sh8000_0000;
          saturated <= 1'b1;
        end else begin
          mean_loss <= sneg ? 32'(-quo) : 32'(quo);
          saturated <= overflow_flag;
        end
        loss_sum      <= '0;
        items_seen    <= '0;
        clamp_flag    <= 1'b0;
        overflow_flag <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !obusy) |=> !empty)
    else $error("result not posted");
  assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == ST_IDLE)
    else $error("take outside idle");
  assert property (@(posedge clk) disable iff (rst)
    $rose(obusy) |-> $past(state) == ST_OUT)
    else $error("result from wrong state");
endmodule

### rtl/batch_loss_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_loss_reduction: streaming MSE / binary cross-entropy batch mean
// Input channel: push/full, one (target, prediction, last) beat per push.
// Result channel: empty/pop, one beat per batch with mean, count and flags.
// loss_kind_we/loss_kind write the mode; write only while idle.
// Front clamps and queues beats (4 deep); back works one beat at a time.
// MSE beats skip the log unit; cross-entropy beats take two logs in turn
// through the shared one-step-per-cycle log squaring unit.
// Batch end runs the bit-serial 48-step divider.
// Reset clears control, counts and flags, mode to MSE; no clearing pass.
// While a result waits unpopped the back stalls at the end of the next
// batch, and the front queue keeps taking beats until full.
// ----------------------------------------------------------------------------
module batch_loss_reduction #(
  parameter int unsigned MAX_ITEMS = blr_pkg::MAX_ITEMS_DEF,
  parameter int unsigned FRAC_BITS = blr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               loss_kind_we,
  input  logic               loss_kind,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] true_value,
  input  logic signed [15:0] predicted_value,
  input  logic               last_in_batch,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] mean_loss,
  output logic [16:0]        pair_count,
  output logic               clamped_seen,
  output logic               saturated
);
  import blr_pkg::*;

  logic      kind;
  logic      q_valid, q_take;
  blr_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_MSE;
    end else if (loss_kind_we) begin
      kind <= loss_kind;
    end
  end

  blr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .push, .full, .true_value, .predicted_value, .last_in_batch,
    .kind, .q_valid, .q_take, .q_item
  );

  blr_back #(.MAX_ITEMS(MAX_ITEMS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .empty, .pop,
    .mean_loss, .pair_count, .clamped_seen, .saturated
  );
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for batch_loss_reduction
// Directed table then random batches in both loss modes, checked result by
// result against a bit-accurate fixed-point predictor or the table's typed
// results; random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import blr_pkg::*;

  localparam int FB = 12;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 47);
  localparam int BATCH_LIMIT = 65536;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [16:0]        cnt;
    logic               clamp;
    logic               sat;
  } batch_res_t;

  typedef struct {
    loss_kind_t  kind;
    shortint     t;
    shortint     p;
    bit          last;
    bit          typed;
    batch_res_t  res;
  } row_t;

  logic clk = 0, rst = 1;
  logic loss_kind_we = 0, loss_kind = 0;
  logic push = 0, pop = 0, last_in_batch = 0;
  logic signed [15:0] true_value = 0, predicted_value = 0;
  logic full, empty, clamped_seen, saturated;
  logic signed [31:0] mean_loss;
  logic [16:0] pair_count;

  batch_res_t pending_means[$];
  int errors = 0;
  bit gaps_on = 1;
  bit hold_req = 0;

  loss_kind_t mode;
  longint acc;
  int unsigned n_pairs;
  bit clamp_f, ovf_f;

  always #2 clk = ~clk;

  batch_loss_reduction u_dut (
    .clk(clk), .rst(rst), .loss_kind_we(loss_kind_we), .loss_kind(loss_kind),
    .push(push), .full(full), .true_value(true_value),
    .predicted_value(predicted_value), .last_in_batch(last_in_batch),
    .empty(empty), .pop(pop), .mean_loss(mean_loss), .pair_count(pair_count),
    .clamped_seen(clamped_seen), .saturated(saturated)
  );

  // -ln(x/ONE) in Q.12 for x in [1, ONE-1]
  function automatic longint unsigned neg_log(input longint unsigned x);
    int k;
    longint unsigned y, frac, nl;
    k = 0;
    frac = 0;
    while (k < 30 && (x >> (k + 1)) != 0) k++;
    y = x << (30 - k);
    for (int i = 0; i < LOG_FRAC; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac |= 64'd1 << (LOG_FRAC - 1 - i);
      end
    end
    nl = (longint'(FB - k) << LOG_FRAC) - frac;
    return (nl * 64'(LN2_Q30) + (64'd1 << (49 - FB))) >> (50 - FB);
  endfunction

  function automatic bit loss_step(input longint t, input longint p, input bit last,
                                   output batch_res_t r);
    longint term, pc, mean;
    longint unsigned mag, q;
    bit sat;
    sat = 0;
    if (mode == KIND_MSE) begin
      term = (t - p) * (t - p);
    end else begin
      pc = p;
      if (pc < 1) begin
        pc = 1;
        clamp_f = 1;
      end else if (pc > ONE - 1) begin
        pc = ONE - 1;
        clamp_f = 1;
      end
      term = t * longint'(neg_log(pc)) + (ONE - t) * longint'(neg_log(ONE - pc));
    end
    acc += term;
    if (acc > SUM_HI) begin
      acc = SUM_HI;
      ovf_f = 1;
    end else if (acc < SUM_LO) begin
      acc = SUM_LO;
      ovf_f = 1;
    end
    n_pairs++;
    if (!last && n_pairs < BATCH_LIMIT) return 0;
    mag = acc < 0 ? -acc : acc;
    q = mag / (longint'(n_pairs) << (2 * FB - 16));
    if (acc >= 0) begin
      if (q > 64'h7FFFFFFF) begin
        q = 64'h7FFFFFFF;
        sat = 1;
      end
      mean = q;
    end else begin
      if (q > 64'h80000000) begin
        q = 64'h80000000;
        sat = 1;
      end
      mean = -longint'(q);
    end
    r.mean = mean[31:0];
    r.cnt = n_pairs[16:0];
    r.clamp = clamp_f;
    r.sat = ovf_f | sat;
    acc = 0;
    n_pairs = 0;
    clamp_f = 0;
    ovf_f = 0;
    return 1;
  endfunction

  task automatic send_beat(input shortint t, input shortint p, input bit last,
                           input bit typed = 0, input batch_res_t typed_res = '0);
    batch_res_t r;
    while (gaps_on && $urandom_range(99) < 22) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    true_value <= t;
    predicted_value <= p;
    last_in_batch <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (loss_step(t, p, last, r))
      pending_means.insert(pending_means.size(), typed ? typed_res : r);
  endtask

  task automatic set_mode(input loss_kind_t k);
    push <= 0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    loss_kind_we <= 1;
    loss_kind <= k;
    @(posedge clk);
    loss_kind_we <= 0;
    mode = k;
  endtask

  function automatic shortint rand_field(input bit prob);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return shortint'($urandom_range(1) ? 32767 : -32768);
    if (sel < 3) return shortint'($urandom);
    if (prob) return shortint'($urandom_range(4096));
    return shortint'($urandom_range(16383)) - 8192;
  endfunction

  // result side: random pop with a hold-off on request
  always @(posedge clk) begin
    int hold;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_means.size() == 0) begin
          $display("%0t unexpected result mean=%0d cnt=%0d", $time, mean_loss, pair_count);
          errors++;
        end else begin
          batch_res_t e;
          e = pending_means.pop_front();
          if (mean_loss !== e.mean) begin
            $display("%0t mean_loss exp %0d got %0d", $time, e.mean, mean_loss);
            errors++;
          end
          if (pair_count !== e.cnt) begin
            $display("%0t pair_count exp %0d got %0d", $time, e.cnt, pair_count);
            errors++;
          end
          if (clamped_seen !== e.clamp) begin
            $display("%0t clamped_seen exp %0b got %0b", $time, e.clamp, clamped_seen);
            errors++;
          end
          if (saturated !== e.sat) begin
            $display("%0t saturated exp %0b got %0b", $time, e.sat, saturated);
            errors++;
          end
        end
      end
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req <= 0;
      end
      if (hold > 0) begin
        hold--;
        pop <= 0;
      end else begin
        pop <= !(gaps_on && $urandom_range(99) < 22);
      end
    end
  end

  row_t dir_rows[] = '{
    '{KIND_MSE, 0, 0, 1, 1, '{32'sd0, 17'd1, 1'b0, 1'b0}},
    '{KIND_MSE, 4096, 0, 1, 1, '{32'sd65536, 17'd1, 1'b0, 1'b0}},
    '{KIND_MSE, 32767, -32768, 0, 0, '0},
    '{KIND_MSE, -32768, 32767, 1, 1, '{32'sd16776704, 17'd2, 1'b0, 1'b0}},
    '{KIND_MSE, -1, 1, 1, 0, '0},
    '{KIND_BCE, 0, 0, 1, 1, '{32'sd16, 17'd1, 1'b1, 1'b0}},
    '{KIND_BCE, 4096, 4096, 1, 1, '{32'sd16, 17'd1, 1'b1, 1'b0}},
    '{KIND_BCE, 0, 2048, 1, 0, '0},
    '{KIND_BCE, 4096, 1, 1, 0, '0},
    '{KIND_BCE, 0, 4095, 1, 0, '0},
    '{KIND_BCE, 32767, 1, 1, 0, '0},
    '{KIND_BCE, -32768, 4095, 1, 0, '0},
    '{KIND_BCE, 2048, -32768, 0, 0, '0},
    '{KIND_BCE, 2048, 32767, 1, 0, '0},
    '{KIND_BCE, 1000, 3000, 0, 0, '0},
    '{KIND_MSE, 1000, 3000, 0, 0, '0},
    '{KIND_MSE, -200, 77, 0, 0, '0},
    '{KIND_BCE, 3000, 100, 1, 0, '0}
  };

  initial begin
    bit prob;
    int blen;
    mode = KIND_MSE;
    acc = 0;
    n_pairs = 0;
    clamp_f = 0;
    ovf_f = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind != mode) set_mode(dir_rows[i].kind);
      send_beat(dir_rows[i].t, dir_rows[i].p, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] ? KIND_MSE : KIND_BCE);
      if (ph == 0) hold_req <= 1;
      gaps_on = (ph != 2);
      for (int n = 0; n < 300; n += blen) begin
        blen = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        prob = ($urandom_range(3) != 0);
        for (int j = 0; j < blen; j++)
          send_beat(rand_field(0), rand_field(prob),
                    (j == blen - 1) || ($urandom_range(49) == 0));
      end
    end
    gaps_on = 1;

    push <= 0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("batch_loss_reduction verification clean");
    else $display("batch_loss_reduction verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("batch_loss_reduction verification failed");
    $finish;
  end

endmodule
